### hdl/cstp_pkg.sv
// ----------------------------------------------------------------------------
// cstp_pkg: shared types and constants of the call stack time profiler
// ----------------------------------------------------------------------------
`default_nettype none
package cstp_pkg;
    localparam int STACK_DEPTH   = 32;
    localparam int TABLE_ENTRIES = 64;
    localparam int MAX_RESULTS   = 32;
    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int SIDX_W = $clog2(STACK_DEPTH);
    localparam int TIDX_W = $clog2(TABLE_ENTRIES);
    localparam int RCNT_W = $clog2(MAX_RESULTS + 1);
    localparam int ID_W    = 32;
    localparam int CALLS_W = 48;
    localparam int TIME_W  = 64;
    localparam int SLOT_W  = 6;

    typedef enum logic [1:0] {
        KIND_CALL = 2'd0, KIND_TAIL = 2'd1, KIND_RET = 2'd2, KIND_READ = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_UPDATED = 2'd0, ST_FULL = 2'd1, ST_READ_OK = 2'd2, ST_READ_EMPTY = 2'd3
    } status_t;

    // table search request / answer between sequencer and search unit
    typedef struct packed {
        logic            start;
        logic [ID_W-1:0] id;
    } srch_req_t;

    typedef struct packed {
        logic              done;
        logic              hit;
        logic              free_ok;
        logic [TIDX_W-1:0] idx;
    } srch_rsp_t;
endpackage
`default_nettype wire

### hdl/call_stack_time_profiler.sv
// ----------------------------------------------------------------------------
// call_stack_time_profiler: shadow call stack with per-function time table
// ----------------------------------------------------------------------------
// Calls push a frame (id, start time, tail mark); a call on a full stack
// sets the overflow flag instead, and a return on an empty stack is dropped.
// A return pops frames while the popped frame was a tail call, the stack is
// not empty and fewer than MAX_RESULTS frames were popped; each popped frame
// searches the function table one entry per cycle in a shared compare unit
// and puts one result on the output. The input is not ready while an event
// is in work. The table valid bits clear at reset; stack and table contents
// need no clearing pass.
`default_nettype none
module call_stack_time_profiler
    import cstp_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // kind[1:0], func_id[33:2], timestamp[97:34], slot[103:98]
    input  wire logic [103:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // entry_id[31:0], call_count[79:32], total_ns[143:80], status[145:144],
    // stack_overflowed[146]
    output logic [151:0]      m_tdata,
    output logic              m_tlast
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001, S_READ = 8'b00000010, S_POP = 8'b00000100,
        S_SRCH = 8'b00001000, S_WAIT = 8'b00010000, S_UPD  = 8'b00100000,
        S_OUT  = 8'b01000000, S_RDOUT = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    logic [ID_W-1:0]    fr_id   [STACK_DEPTH];
    logic [TIME_W-1:0]  fr_start[STACK_DEPTH];
    logic               fr_tail [STACK_DEPTH];
    logic [ID_W-1:0]    en_id   [TABLE_ENTRIES];
    logic [CALLS_W-1:0] en_calls[TABLE_ENTRIES];
    logic [TIME_W-1:0]  en_time [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;

    logic [SP_W-1:0]   sp_reg;
    logic              ovf_reg;
    logic [TIME_W-1:0] now_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [RCNT_W-1:0] n_reg;
    logic [ID_W-1:0]   pid_reg;
    logic [TIME_W-1:0] pstart_reg;
    logic              ptail_reg;
    logic [TIME_W-1:0] elapsed_reg;
    logic [TIDX_W-1:0] eidx_reg;
    logic              hit_reg;
    logic [CALLS_W-1:0] oc_reg;
    logic [TIME_W-1:0]  ot_reg;
    logic [ID_W-1:0]    oid_reg;
    logic [1:0]         ost_reg;
    logic               olast_reg;
    logic [ID_W-1:0]    rd_id_reg;
    logic [CALLS_W-1:0] rd_calls_reg;
    logic [TIME_W-1:0]  rd_time_reg;

    srch_req_t          sreq;
    srch_rsp_t          srsp;
    logic [TIDX_W-1:0]  s_rd_idx;
    logic [ID_W-1:0]    s_rd_id_reg;

    logic [SIDX_W-1:0] top;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] base_t;
    logic [CALLS_W-1:0] base_c;
    logic              more;

    assign top = SIDX_W'(sp_reg - 1'b1);
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT) || (state_reg == S_RDOUT);
    assign m_tdata  = {5'd0, ovf_reg, ost_reg, ot_reg, oc_reg, oid_reg};
    assign m_tlast  = olast_reg;
    assign sreq.start = (state_reg == S_POP);
    assign sreq.id    = fr_id[top];

    cstp_search u_search (
        .aclk(aclk), .aresetn(aresetn), .req(sreq), .valid_vec(valid_reg),
        .rd_idx(s_rd_idx), .rd_id(s_rd_id_reg), .rsp(srsp)
    );

    always_ff @(posedge aclk) s_rd_id_reg <= en_id[s_rd_idx];

    // fresh entry starts at zero
    assign base_t = hit_reg ? rd_time_reg  : '0;
    assign base_c = hit_reg ? rd_calls_reg : '0;
    assign sum    = {1'b0, base_t} + {1'b0, elapsed_reg};
    assign more   = ptail_reg && sp_reg != '0 && n_reg != RCNT_W'(MAX_RESULTS);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_tvalid) begin
                case (kind_t'(s_tdata[1:0]))
                    KIND_READ: state_next = S_READ;
                    KIND_RET:  state_next = (sp_reg == '0) ? S_IDLE : S_POP;
                    default:   state_next = S_IDLE;
                endcase
            end
            S_READ:  state_next = S_RDOUT;
            S_POP:   state_next = S_SRCH;
            S_SRCH:  if (srsp.done) state_next = S_WAIT;
            S_WAIT:  state_next = S_UPD;
            S_UPD:   state_next = S_OUT;
            S_OUT:   if (m_tready) state_next = olast_reg ? S_IDLE : S_POP;
            S_RDOUT: if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sp_reg    <= '0;
            ovf_reg   <= 1'b0;
            valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && s_tvalid) begin
                if (s_tdata[1:0] == KIND_CALL || s_tdata[1:0] == KIND_TAIL) begin
                    if (sp_reg == SP_W'(STACK_DEPTH)) ovf_reg <= 1'b1;
                    else sp_reg <= sp_reg + 1'b1;
                end
            end
            if (state_reg == S_POP) sp_reg <= sp_reg - 1'b1;
            if (state_reg == S_SRCH && srsp.done && (srsp.hit || srsp.free_ok))
                valid_reg[srsp.idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_tvalid) begin
            now_reg  <= s_tdata[97:34];
            slot_reg <= s_tdata[103:98];
            n_reg    <= '0;
            if ((s_tdata[1:0] == KIND_CALL || s_tdata[1:0] == KIND_TAIL)
                    && sp_reg != SP_W'(STACK_DEPTH)) begin
                fr_id[sp_reg[SIDX_W-1:0]]    <= s_tdata[33:2];
                fr_start[sp_reg[SIDX_W-1:0]] <= s_tdata[97:34];
                fr_tail[sp_reg[SIDX_W-1:0]]  <= s_tdata[1:0] == KIND_TAIL;
            end
        end
        // table read port, registered
        rd_id_reg    <= en_id[(state_reg == S_IDLE) ? s_tdata[98 +: TIDX_W] : eidx_reg];
        rd_calls_reg <= en_calls[(state_reg == S_IDLE) ? s_tdata[98 +: TIDX_W] : eidx_reg];
        rd_time_reg  <= en_time[(state_reg == S_IDLE) ? s_tdata[98 +: TIDX_W] : eidx_reg];
        if (state_reg == S_READ) begin
            olast_reg <= 1'b1;
            if (valid_reg[slot_reg[TIDX_W-1:0]]) begin
                oid_reg <= rd_id_reg; oc_reg <= rd_calls_reg; ot_reg <= rd_time_reg;
                ost_reg <= ST_READ_OK;
            end else begin
                oid_reg <= '0; oc_reg <= '0; ot_reg <= '0; ost_reg <= ST_READ_EMPTY;
            end
        end
        if (state_reg == S_POP) begin
            pid_reg     <= fr_id[top];
            ptail_reg   <= fr_tail[top];
            elapsed_reg <= now_reg - fr_start[top];
            n_reg       <= n_reg + 1'b1;
        end
        if (state_reg == S_SRCH && srsp.done) begin
            eidx_reg <= srsp.idx;
            hit_reg  <= srsp.hit;
            ost_reg  <= (srsp.hit || srsp.free_ok) ? ST_UPDATED : ST_FULL;
        end
        if (state_reg == S_UPD) begin
            oid_reg   <= pid_reg;
            olast_reg <= !more;
            if (ost_reg == ST_FULL) begin
                oc_reg <= '0; ot_reg <= '0;
            end else begin
                oc_reg <= (base_c == '1) ? base_c : base_c + 1'b1;
                ot_reg <= sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                en_id[eidx_reg]    <= pid_reg;
                en_calls[eidx_reg] <= (base_c == '1) ? base_c : base_c + 1'b1;
                en_time[eidx_reg]  <= sum[TIME_W] ? '1 : sum[TIME_W-1:0];
            end
        end
    end
endmodule
`default_nettype wire

### hdl/cstp_search.sv
// ----------------------------------------------------------------------------
// cstp_search: table lookup, one entry compared per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module cstp_search
    import cstp_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire srch_req_t                req,
    input  wire logic [TABLE_ENTRIES-1:0] valid_vec,
    output logic [TIDX_W-1:0]             rd_idx,
    input  wire logic [ID_W-1:0]          rd_id,
    output srch_rsp_t                     rsp
);
    logic              busy_reg, busy_next;
    logic [TIDX_W:0]   ptr_reg, ptr_next;
    logic              free_ok_reg, free_ok_next;
    logic [TIDX_W-1:0] free_reg, free_next;
    logic [TIDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic              cmp_v_reg, cmp_v_next;
    logic [ID_W-1:0]   id_reg, id_next;
    srch_rsp_t         rsp_next;

    assign rd_idx = ptr_reg[TIDX_W-1:0];

    always_comb begin
        busy_next    = busy_reg;
        ptr_next     = ptr_reg;
        free_ok_next = free_ok_reg;
        free_next    = free_reg;
        cmp_idx_next = cmp_idx_reg;
        cmp_v_next   = 1'b0;
        id_next      = id_reg;
        rsp_next     = '0;
        if (req.start) begin
            busy_next    = 1'b1;
            ptr_next     = '0;
            free_ok_next = 1'b0;
            id_next      = req.id;
        end else if (busy_reg) begin
            // compare stage: entry read last cycle
            if (cmp_v_reg && valid_vec[cmp_idx_reg] && rd_id == id_reg) begin
                busy_next     = 1'b0;
                rsp_next.done = 1'b1;
                rsp_next.hit  = 1'b1;
                rsp_next.idx  = cmp_idx_reg;
            end else begin
                if (cmp_v_reg && !valid_vec[cmp_idx_reg] && !free_ok_reg) begin
                    free_ok_next = 1'b1;
                    free_next    = cmp_idx_reg;
                end
                if (ptr_reg == (TIDX_W+1)'(TABLE_ENTRIES) && !cmp_v_reg) begin
                    busy_next        = 1'b0;
                    rsp_next.done    = 1'b1;
                    rsp_next.free_ok = free_ok_next;
                    rsp_next.idx     = free_next;
                end else if (ptr_reg != (TIDX_W+1)'(TABLE_ENTRIES)) begin
                    cmp_idx_next = ptr_reg[TIDX_W-1:0];
                    cmp_v_next   = 1'b1;
                    ptr_next     = ptr_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            cmp_v_reg <= 1'b0;
            rsp       <= '0;
        end else begin
            busy_reg  <= busy_next;
            cmp_v_reg <= cmp_v_next;
            rsp       <= rsp_next;
        end
        ptr_reg     <= ptr_next;
        free_ok_reg <= free_ok_next;
        free_reg    <= free_next;
        cmp_idx_reg <= cmp_idx_next;
        id_reg      <= id_next;
    end
endmodule
`default_nettype wire
